// ===== rtl/keyed_mantissa_extractor_defines.svh =====
// Assertion macros shared by the keyed mantissa extractor RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef KEYED_MANTISSA_EXTRACTOR_DEFINES_SVH
`define KEYED_MANTISSA_EXTRACTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define KME_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KME_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KME_ASSERT(label, clk, rst_n, prop, msg)
`define KME_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/kme_pkg.sv =====
// Shared types, constants and lookup functions for the keyed mantissa extractor.
// No dependencies.
package kme_pkg;

  typedef struct packed {
    logic signed [63:0] raw_value;
    logic [31:0]        tile_row;
    logic [31:0]        tile_col;
  } kme_in_t;

  typedef struct packed {
    logic signed [3:0] mantissa;
    logic              last_of_tile;
  } kme_out_t;

  localparam logic [1:0] CFG_KEY_WORD_0 = 2'd0;
  localparam logic [1:0] CFG_KEY_WORD_1 = 2'd1;
  localparam logic [1:0] CFG_KEY_WORD_2 = 2'd2;
  localparam logic [1:0] CFG_KEY_WORD_3 = 2'd3;
  localparam int unsigned CFG_NUM_REGS = 4;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;
  localparam logic [31:0] LANE_TAG = 32'h4D58424C;
  localparam logic [31:0] GOLDEN_MUL = 32'h9E3779B9;
  localparam int unsigned MAX_NIBBLES = 4096;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_tile;   // capture row/col, clear block index
    logic load_item;    // capture raw value, compute tag
    logic init_block;   // load the round state from key and counter
    logic next_block;   // advance block index before init
    logic do_round;     // one column or diagonal half round
    logic finalize;     // keystream = state + init
    logic take_nibble;  // consume one nibble
  } kme_cmd_t;

  typedef struct packed {
    logic accept;   // current nibble lands in the set
    logic wrap;     // current nibble is the last of the block
  } kme_sts_t;

  function automatic logic nib_accept(input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd8, 4'd9, 4'd11: nib_accept = 1'b0;
      default:                       nib_accept = 1'b1;
    endcase
  endfunction

  function automatic logic [3:0] nib_value(input logic [3:0] m);
    case (m)
      4'd2:    nib_value = 4'd1;
      4'd4:    nib_value = 4'd2;
      4'd5:    nib_value = 4'd3;
      4'd6:    nib_value = 4'd4;
      4'd7:    nib_value = 4'd6;
      4'd10:   nib_value = 4'hF;
      4'd12:   nib_value = 4'hE;
      4'd13:   nib_value = 4'hD;
      4'd14:   nib_value = 4'hC;
      4'd15:   nib_value = 4'hA;
      default: nib_value = 4'd0;
    endcase
  endfunction

endpackage

// ===== rtl/kme_datapath.sv =====
// Datapath: key registers, ChaCha round state, keystream store, nibble tap and tag.
// Depends on kme_pkg.
module kme_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  kme_pkg::kme_in_t   in_data,
  input  kme_pkg::kme_cmd_t  cmd,
  output kme_pkg::kme_sts_t  sts,
  output logic [3:0]         nib_val
);
  import kme_pkg::*;

  logic [63:0] key_r [4];
  logic [31:0] row_r, col_r, blk_r, tag_r, fold_r;
  logic [31:0] st_r [16];
  logic [31:0] ks_r [16];
  logic        diag_r;
  logic [6:0]  pos_r;
  logic        tag_stage_r;
  logic [31:0] init_w [16];
  logic [31:0] qr_out [16];
  logic [31:0] word_w;
  logic [3:0]  mixed_w;
  logic [31:0] lo_w, hi_w;
  logic        fits_w;

  function automatic logic [127:0] qr(input logic [31:0] a, b, c, d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b; td = d ^ ta; td = {td[15:0], td[31:16]};
    tc = c + td; tb = b ^ tc; tb = {tb[19:0], tb[31:20]};
    ta = ta + tb; td = td ^ ta; td = {td[23:0], td[31:24]};
    tc = tc + td; tb = tb ^ tc; tb = {tb[24:0], tb[31:25]};
    qr = {ta, tb, tc, td};
  endfunction

  always_comb begin
    init_w[0] = SIGMA_0; init_w[1] = SIGMA_1; init_w[2] = SIGMA_2; init_w[3] = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = key_r[k][31:0];
      init_w[5 + 2 * k] = key_r[k][63:32];
    end
    init_w[12] = blk_r;
    init_w[13] = col_r ^ LANE_TAG;
    init_w[14] = col_r;
    init_w[15] = row_r;
  end

  // Four parallel quarter rounds: one column or one diagonal half round.
  always_comb begin
    for (int k = 0; k < 16; k++) qr_out[k] = st_r[k];
    if (!diag_r) begin
      for (int q = 0; q < 4; q++) begin
        {qr_out[q], qr_out[4 + q], qr_out[8 + q], qr_out[12 + q]} =
          qr(st_r[q], st_r[4 + q], st_r[8 + q], st_r[12 + q]);
      end
    end else begin
      {qr_out[0], qr_out[5], qr_out[10], qr_out[15]} = qr(st_r[0], st_r[5], st_r[10], st_r[15]);
      {qr_out[1], qr_out[6], qr_out[11], qr_out[12]} = qr(st_r[1], st_r[6], st_r[11], st_r[12]);
      {qr_out[2], qr_out[7], qr_out[8], qr_out[13]} = qr(st_r[2], st_r[7], st_r[8], st_r[13]);
      {qr_out[3], qr_out[4], qr_out[9], qr_out[14]} = qr(st_r[3], st_r[4], st_r[9], st_r[14]);
    end
  end

  assign lo_w = in_data.raw_value[31:0];
  assign hi_w = in_data.raw_value[63:32];
  assign fits_w = (hi_w == 32'h0 && !lo_w[31]) || (hi_w == 32'hFFFFFFFF && lo_w[31]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
    end else if (cfg_valid) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_tile) begin
      row_r <= in_data.tile_row;
      col_r <= in_data.tile_col;
      blk_r <= '0;
      pos_r <= '0;
    end
    if (cmd.load_item) fold_r <= fits_w ? lo_w : (lo_w ^ hi_w);
    tag_stage_r <= cmd.load_item;
    if (tag_stage_r) tag_r <= fold_r * GOLDEN_MUL;
    if (cmd.next_block) blk_r <= blk_r + 32'd1;
    if (cmd.init_block) begin
      for (int k = 0; k < 16; k++) st_r[k] <= init_w[k];
      diag_r <= 1'b0;
    end else if (cmd.do_round) begin
      for (int k = 0; k < 16; k++) st_r[k] <= qr_out[k];
      diag_r <= ~diag_r;
    end
    if (cmd.finalize) begin
      for (int k = 0; k < 16; k++) ks_r[k] <= st_r[k] + init_w[k];
    end
    if (cmd.take_nibble) pos_r <= pos_r + 7'd1;
  end

  assign word_w  = ks_r[pos_r[6:3]];
  assign mixed_w = word_w[pos_r[2:0] * 4 +: 4] ^ tag_r[31:28];
  assign sts.accept = nib_accept(mixed_w);
  assign sts.wrap   = (pos_r == 7'd127);
  assign nib_val    = nib_value(mixed_w);

endmodule

// ===== rtl/kme_ctrl.sv =====
// Controller: sequences tile start, block generation, and nibble rejection.
// Depends on kme_pkg and the shared assertion macros.
`include "keyed_mantissa_extractor_defines.svh"
module kme_ctrl #(
  parameter int unsigned TILE_SIZE     = 32,
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              last_r,
  output logic              zero_mant,
  input  kme_pkg::kme_sts_t sts,
  output kme_pkg::kme_cmd_t cmd
);
  import kme_pkg::*;

  localparam int EW = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);
  localparam int TW = $clog2(MAX_NIBBLES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAG   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_NIB   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [EW-1:0] elem_r;
  logic [RW-1:0] rnd_r;
  logic [TW-1:0] tries_r;
  logic          found_r;   // result already chosen; block refill pending
  logic          build_r;   // a keystream block must be built in S_TAG
  logic          first_w, fire_in;

  assign first_w  = (elem_r == '0);
  assign in_ready = (state_r == S_IDLE);
  assign fire_in  = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (fire_in) begin
        cmd.load_item  = 1'b1;
        cmd.latch_tile = first_w;
        state_nxt = S_TAG;
      end
      S_TAG: begin
        if (build_r) begin
          cmd.init_block = 1'b1;
          state_nxt = S_ROUND;
        end else begin
          state_nxt = S_NIB;
        end
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        if (rnd_r == RW'(2 * DOUBLE_ROUNDS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finalize = 1'b1;
        state_nxt = found_r ? S_OUT : S_NIB;
      end
      S_NIB: begin
        cmd.take_nibble = 1'b1;
        if (sts.wrap) begin
          cmd.next_block = 1'b1;
          state_nxt = S_TAG;
        end else if (sts.accept || tries_r == TW'(MAX_NIBBLES - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      elem_r  <= '0;
      rnd_r   <= '0;
      tries_r <= '0;
      found_r <= 1'b0;
      build_r <= 1'b0;
      last_r  <= 1'b0;
      zero_mant <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.init_block) rnd_r <= '0;
      else if (cmd.do_round) rnd_r <= rnd_r + RW'(1);
      if (fire_in) begin
        tries_r <= '0;
        found_r <= 1'b0;
        build_r <= first_w;
        last_r  <= (32'(elem_r) + 32'd1 >= TILE_SIZE);
        elem_r  <= (32'(elem_r) + 32'd1 >= TILE_SIZE) ? '0 : elem_r + EW'(1);
      end
      if (cmd.take_nibble) begin
        tries_r <= tries_r + TW'(1);
        if (sts.accept || tries_r == TW'(MAX_NIBBLES - 1)) begin
          found_r   <= 1'b1;
          zero_mant <= !sts.accept;
        end
      end
      // A block is built on the first element of a tile and after each wrap.
      if (cmd.next_block) build_r <= 1'b1;
      if (cmd.init_block) build_r <= 1'b0;
    end
  end

  `KME_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `KME_ASSERT(a_no_in_busy, clk, rst_n, state_r != S_IDLE |-> !in_ready, "accepted while busy")
  `KME_ASSERT(a_round_bound, clk, rst_n, state_r == S_ROUND |-> rnd_r < RW'(2 * DOUBLE_ROUNDS), "round overrun")
endmodule

// ===== rtl/keyed_mantissa_extractor.sv =====
// Top level of the keyed mantissa extractor: ChaCha20 keystream rejection sampler.
// Depends on kme_pkg, kme_ctrl, kme_datapath and the shared assertion macros.
//
//   channel  dir  ports                            beat
//   in       in   in_valid/in_ready/in_data        one raw value with tile row/col
//   out      out  out_valid/out_ready/out_data     mantissa and last_of_tile
//   cfg      in   cfg_valid/cfg_ready/cfg_index/   one 64-bit key word
//                 cfg_data
//
// An element takes its setup in S_IDLE and S_TAG, one step per nibble examined
// in S_NIB, and the output beat in S_OUT. A keystream block is built on the
// first element of a tile and after every 128 nibbles: init, 2*DOUBLE_ROUNDS
// half rounds in the shared half-round unit, then finalize. Reset is
// synchronous and active low; the key words clear to zero. One element is in
// flight at a time, and a stalled result holds in_ready low until taken.
module keyed_mantissa_extractor #(
  parameter int unsigned TILE_SIZE     = 32,
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kme_pkg::kme_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kme_pkg::kme_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import kme_pkg::*;

  kme_cmd_t    cmd;
  kme_sts_t    sts;
  logic [3:0]  nib_val;
  logic [3:0]  mant_r;
  logic        last_w, zero_w;

  // Key writes are always taken; software must write only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  kme_ctrl #(.TILE_SIZE(TILE_SIZE), .DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .out_valid,
    .last_r(last_w), .zero_mant(zero_w), .sts, .cmd
  );

  kme_datapath u_dp (
    .clk, .rst_n, .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .in_data, .cmd, .sts, .nib_val
  );

  // Capture the mapped value of the nibble that was accepted.
  always_ff @(posedge clk) begin
    if (cmd.take_nibble && sts.accept) mant_r <= nib_val;
  end

  assign out_data.mantissa     = zero_w ? 4'sd0 : mant_r;
  assign out_data.last_of_tile = last_w;
endmodule
